/* rtl/core/rost_pkg.sv */
// Package for the object slot table: request codes, page actions, slot record.
// No dependencies.
package rost_pkg;

  typedef enum logic [2:0] {
    FUNC_CREATE_ANON = 3'd0,
    FUNC_CREATE_FILE = 3'd1,
    FUNC_REF         = 3'd2,
    FUNC_UNREF       = 3'd3,
    FUNC_RESOLVE     = 3'd4
  } func_t;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_FILE = 2'd1;
  localparam logic [1:0] ACT_ZERO = 2'd2;

  localparam int ID_W = 6;
  localparam int ID_LIMIT = 64;
  localparam logic [31:0] REF_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        is_file;
    logic [31:0] refcount;
    logic [15:0] fnum;
    logic [47:0] fbase;
    logic [47:0] fdata_bytes;
    logic [36:0] npages;
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_OUT  = 2'd2
  } state_t;

endpackage

/* rtl/core/rost_if.sv */
// Valid/ready channel interface carrying a packed payload.
// Depends on nothing.
interface rost_if #(
  parameter int W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/rost_slot_mem.sv */
// Slot record memory, one write and one registered read port.
// Depends on rost_pkg.
module rost_slot_mem #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic            clk,
  input  logic [AW-1:0]   raddr,
  output rost_pkg::slot_t rdata,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  rost_pkg::slot_t wdata
);
  import rost_pkg::*;

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/refcounted_object_slot_table.sv */
// Top level of the reference-counted object slot table.
// Depends on rost_pkg, rost_if and rost_slot_mem.
//
// The block serves one request at a time. A request transfer is taken in the
// idle state, and the slot memory samples the requested id at that same edge
// (the lowest free slot comes from a presence bitmap through a priority
// encoder at transfer time). In the execute cycle that follows, the slot
// record is on the memory output; the block checks it, modifies it, writes it
// back and loads the result register. The next cycle presents the result. An
// item passes through the idle state with the request transfer, the execute
// state, and the output state with the result transfer, which holds while the
// sink is not ready. The registered read of the slot memory sets the execute
// cycle apart from the transfer. Presence bits live in flip-flops and are
// cleared at reset, so no clearing pass is needed. Slot 0 is never handed
// out, and ref or unref of id 0 is a successful no-op. Page offsets must be
// page aligned.
module refcounted_object_slot_table #(
  parameter int SLOT_COUNT = 64,
  parameter int PAGE_BYTES = 4096
) (
  input logic clk,
  input logic rst,
  rost_if.sink   req,
  rost_if.source rsp
);
  import rost_pkg::*;

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PSH = $clog2(PAGE_BYTES);
  localparam int ALLOC_LIM = (SLOT_COUNT < ID_LIMIT) ? SLOT_COUNT : ID_LIMIT;

  // Request payload, in the order of the fields, msb first.
  typedef struct packed {
    logic [2:0]  func;
    logic [5:0]  slot_id;
    logic [31:0] tid;
    logic [47:0] obj_bytes;
    logic [15:0] fnum;
    logic [47:0] fbase;
    logic [47:0] fdata_bytes;
    logic [47:0] fbytes;
    logic        file_found;
    logic [47:0] obj_pos;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [5:0]  new_object_id;
    logic [1:0]  page_action;
    logic [15:0] page_file_index;
    logic [48:0] page_file_offset;
    logic [31:0] page_owner;
  } rsp_t;

  state_t state, state_next;
  req_t   r;
  rsp_t   res;
  logic [SLOT_COUNT-1:0] present;
  logic [AW-1:0] free_id;
  logic          free_ok;
  logic          id_valid;
  logic          pres_r;

  slot_t rdata, wdata;
  logic  we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [AW-1:0] rid;

  logic [AW-1:0] free_found;
  logic          free_any;

  // Lowest free slot from 1 up.
  always_comb begin
    free_found = '0;
    free_any = 1'b0;
    for (int k = ALLOC_LIM - 1; k >= 1; k--) begin
      if (!present[k]) begin
        free_found = AW'(k);
        free_any = 1'b1;
      end
    end
  end

  req_t req_d;
  assign req_d = req.data;
  assign req.ready = (state == ST_IDLE);

  // The memory samples the offered id every edge; the value taken at the
  // request transfer is what the execute cycle sees.
  assign raddr = AW'(req_d.slot_id);
  assign rid = AW'(r.slot_id);

  rost_slot_mem #(.DEPTH(SLOT_COUNT), .AW(AW)) u_mem (
    .clk(clk), .raddr(raddr), .rdata(rdata),
    .we(we), .waddr(waddr), .wdata(wdata)
  );

  always_comb begin
    unique case (state)
      ST_IDLE: state_next = (req.valid) ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_next = ST_OUT;
      ST_OUT:  state_next = (rsp.ready) ? ST_IDLE : ST_OUT;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the request; the slot memory samples the same id at this edge.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      r        <= req_d;
      free_id  <= free_found;
      free_ok  <= free_any;
      id_valid <= (req_d.slot_id != 6'd0) &&
                  ({26'd0, req_d.slot_id} < 32'(SLOT_COUNT));
    end
  end

  assign pres_r = id_valid && present[rid];

  // Check, modify, write back.
  logic        ok;
  logic        do_create, do_free;
  rsp_t        res_c;
  logic [48:0] fsum;
  logic [47:0] frem;
  logic [36:0] pg_full;
  logic [36:0] pidx;

  always_comb begin
    ok = 1'b0;
    do_create = 1'b0;
    do_free = 1'b0;
    we = 1'b0;
    waddr = rid;
    wdata = rdata;
    res_c = '0;
    frem = r.fbytes - r.fbase;
    fsum = {1'b0, rdata.fbase} + {1'b0, r.obj_pos};
    pg_full = 37'((({1'b0, r.obj_bytes} + 49'(PAGE_BYTES - 1)) >> PSH));
    pidx = 37'(r.obj_pos >> PSH);
    case (r.func)
      FUNC_CREATE_ANON, FUNC_CREATE_FILE: begin
        if ((r.obj_bytes != 48'd0) && free_ok &&
            (r.func == FUNC_CREATE_ANON ||
             (r.file_found && r.fbase <= r.fbytes &&
              r.fdata_bytes <= frem && r.fdata_bytes <= r.obj_bytes))) begin
          ok = 1'b1;
          do_create = 1'b1;
          we = 1'b1;
          waddr = free_id;
          wdata.is_file = (r.func == FUNC_CREATE_FILE);
          wdata.refcount = 32'd1;
          wdata.fnum = (r.func == FUNC_CREATE_FILE) ? r.fnum : 16'd0;
          wdata.fbase = (r.func == FUNC_CREATE_FILE) ? r.fbase : 48'd0;
          wdata.fdata_bytes = (r.func == FUNC_CREATE_FILE) ? r.fdata_bytes : r.obj_bytes;
          wdata.npages = pg_full;
          res_c.new_object_id = 6'(free_id);
        end
      end
      FUNC_REF: begin
        if (r.slot_id == 6'd0) begin
          ok = 1'b1;
        end else if (pres_r && rdata.refcount != REF_MAX) begin
          ok = 1'b1;
          we = 1'b1;
          wdata.refcount = rdata.refcount + 32'd1;
        end
      end
      FUNC_UNREF: begin
        if (r.slot_id == 6'd0) begin
          ok = 1'b1;
        end else if (pres_r && rdata.refcount != 32'd0) begin
          ok = 1'b1;
          we = 1'b1;
          wdata.refcount = rdata.refcount - 32'd1;
          do_free = (rdata.refcount == 32'd1);
        end
      end
      FUNC_RESOLVE: begin
        if (pres_r && r.obj_pos[PSH-1:0] == '0 && pidx < rdata.npages) begin
          ok = 1'b1;
          if (rdata.is_file && r.obj_pos < rdata.fdata_bytes) begin
            res_c.page_action = ACT_FILE;
            res_c.page_file_index = rdata.fnum;
            res_c.page_file_offset = fsum;
          end else begin
            res_c.page_action = ACT_ZERO;
            res_c.page_owner = r.tid;
          end
        end
      end
      default: ok = 1'b0;
    endcase
    if (state != ST_EXEC) begin
      we = 1'b0;
      do_create = 1'b0;
      do_free = 1'b0;
    end
    if (!ok) begin
      res_c = '0;
    end
    res_c.status = !ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else begin
      if (do_create) begin
        present[free_id] <= 1'b1;
      end
      if (do_free) begin
        present[rid] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      res <= res_c;
    end
  end

  assign rsp.valid = (state == ST_OUT);
  assign rsp.data = res;

  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == ST_EXEC))
    else $error("accepted request did not start execution");
  assert property (@(posedge clk) disable iff (rst)
    do_create |-> !present[free_id] && free_id != '0)
    else $error("create took a busy slot or slot zero");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |=> rsp.valid)
    else $error("result not presented after execution");
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> $stable(res))
    else $error("result changed while stalled");
endmodule
